/* hdl/nmwx_pkg.sv */
// shared types and constants for the nand metadata whitening removal block
// no dependencies; imported by the generator, the lanes and the top level
`timescale 1ns / 1ps
`default_nettype none

package nmwx_pkg;

  localparam int WORD_W     = 32;
  localparam int META_WORDS = 3;

  // linear congruential generator: value = value * GEN_MUL + GEN_INC (mod 2^32)
  localparam logic [WORD_W-1:0] GEN_SEED = 32'h50F4546A;
  localparam logic [WORD_W-1:0] GEN_MUL  = 32'h0019660D;
  localparam logic [WORD_W-1:0] GEN_INC  = 32'h3C6EF35F;

  // per-stage load enables of the lane pipeline
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
    logic en4;
  } pipe_ctl_t;

  // key table write from the generator
  typedef struct packed {
    logic              en;
    logic [WORD_W-1:0] data;
  } tbl_wr_t;

endpackage

`default_nettype wire

/* hdl/nand_meta_whitening_xor_top.sv */
// top level of the nand metadata whitening removal block
// depends on nmwx_pkg, nmwx_gen and nmwx_lane
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------------------
//   in      | input     | in_valid / in_stall | in_page_address, in_meta_word0..2
//   out     | output    | out_valid/out_stall | out_plain_word0..2
//
// one transfer per cycle sustained while out is not stalled; each item passes
// the sum, quotient estimate, remainder, table read and output registers
// after reset the generator fills the key table, one lcg step per cycle,
// writing an entry at the end of each run of steps, with in_stall high
// reset is synchronous, active low, and clears the valid bits and generator
// a stall on out backs the pipeline up stage by stage; bubbles are squeezed
// out, so in keeps taking transfers while a finished result waits, until all stages are full
`timescale 1ns / 1ps
`default_nettype none

module nand_meta_whitening_xor_top #(
  parameter int TABLE_ENTRIES   = 256,
  parameter int STEPS_PER_ENTRY = 763
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_page_address,
  input  wire logic [31:0] in_meta_word0,
  input  wire logic [31:0] in_meta_word1,
  input  wire logic [31:0] in_meta_word2,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_plain_word0,
  output logic [31:0]      out_plain_word1,
  output logic [31:0]      out_plain_word2
);
  import nmwx_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  // table fill
  tbl_wr_t          tbl_wr;
  logic [IDX_W-1:0] tbl_wr_addr;
  logic             fill_done;

  nmwx_gen #(
    .TABLE_ENTRIES  (TABLE_ENTRIES),
    .STEPS_PER_ENTRY(STEPS_PER_ENTRY)
  ) u_gen (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (tbl_wr),
    .wr_addr(tbl_wr_addr),
    .done   (fill_done)
  );

  // pipeline control: a stage loads when it is empty or the next one loads
  logic      v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic      v1_nxt, v2_nxt, v3_nxt, v4_nxt, out_valid_nxt;
  logic      adv_out, in_xfer;
  pipe_ctl_t ctl;

  assign adv_out  = !out_valid_r || !out_stall;
  assign ctl.en4  = !v4_r || adv_out;
  assign ctl.en3  = !v3_r || ctl.en4;
  assign ctl.en2  = !v2_r || ctl.en3;
  assign ctl.en1  = !v1_r || ctl.en2;
  assign in_stall = !fill_done || !ctl.en1;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    v1_nxt        = ctl.en1 ? in_xfer : v1_r;
    v2_nxt        = ctl.en2 ? v1_r : v2_r;
    v3_nxt        = ctl.en3 ? v2_r : v3_r;
    v4_nxt        = ctl.en4 ? v3_r : v4_r;
    out_valid_nxt = adv_out ? v4_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      v3_r        <= v3_nxt;
      v4_r        <= v4_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // lanes: word k looks up entry (page_address + k) mod TABLE_ENTRIES
  logic [WORD_W-1:0] meta_word  [META_WORDS];
  logic [WORD_W-1:0] lane_plain [META_WORDS];
  logic [WORD_W-1:0] plain_r    [META_WORDS];

  assign meta_word[0] = in_meta_word0;
  assign meta_word[1] = in_meta_word1;
  assign meta_word[2] = in_meta_word2;

  for (genvar k = 0; k < META_WORDS; k++) begin : g_lane
    logic [WORD_W-1:0] lane_sum;

    // the 32-bit sum wraps before the reduction, as the address adder does
    assign lane_sum = in_page_address + WORD_W'(k);

    nmwx_lane #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_lane (
      .clk       (clk),
      .ctl       (ctl),
      .in_sum    (lane_sum),
      .in_word   (meta_word[k]),
      .wr        (tbl_wr),
      .wr_addr   (tbl_wr_addr),
      .plain_word(lane_plain[k])
    );
  end

  // merge: one output register gathers the three lane results
  always_ff @(posedge clk) begin
    if (adv_out) begin
      for (int k = 0; k < META_WORDS; k++) begin
        plain_r[k] <= lane_plain[k];
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_plain_word0 = plain_r[0];
  assign out_plain_word1 = plain_r[1];
  assign out_plain_word2 = plain_r[2];

  // no transfer in before the key table is complete
  a_no_xfer_before_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> fill_done)
    else $error("input transfer before key table fill finished");

  // once filled, the table stays filled until the next reset
  a_fill_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fill_done |=> fill_done)
    else $error("key table fill flag dropped");

  // no table write after the fill has finished
  a_no_write_after_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fill_done |-> !tbl_wr.en)
    else $error("key table written after fill");

  // an accepted item always occupies the first stage on the next cycle
  a_xfer_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> v1_r)
    else $error("accepted item lost at pipeline entry");

  // a result never appears before the table exists
  a_no_out_before_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> fill_done)
    else $error("result presented before key table fill finished");

endmodule

`default_nettype wire

/* hdl/nmwx_gen.sv */
// key table fill generator: steps the lcg once per cycle and writes an entry
// at the end of each run of steps; depends on nmwx_pkg
`timescale 1ns / 1ps
`default_nettype none

module nmwx_gen #(
  parameter int TABLE_ENTRIES   = 256,
  parameter int STEPS_PER_ENTRY = 763
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  output nmwx_pkg::tbl_wr_t                      wr,
  output logic [$clog2(TABLE_ENTRIES)-1:0]       wr_addr,
  output logic                                   done
);
  import nmwx_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int ENT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int STEP_W = (STEPS_PER_ENTRY > 1) ? $clog2(STEPS_PER_ENTRY) : 1;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS_PER_ENTRY - 1);
  localparam logic [ENT_W-1:0]  ALL_ENT   = ENT_W'(TABLE_ENTRIES);

  logic [WORD_W-1:0] value_r, value_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [ENT_W-1:0]  entry_r, entry_nxt;
  logic [WORD_W-1:0] lcg_val;
  logic              last_step;

  assign lcg_val   = value_r * GEN_MUL + GEN_INC;
  assign done      = (entry_r == ALL_ENT);
  assign last_step = (step_r == LAST_STEP);

  always_comb begin
    value_nxt = value_r;
    step_nxt  = step_r;
    entry_nxt = entry_r;
    if (!done) begin
      value_nxt = lcg_val;
      if (last_step) begin
        step_nxt  = '0;
        entry_nxt = entry_r + ENT_W'(1);
      end else begin
        step_nxt = step_r + STEP_W'(1);
      end
    end
  end

  assign wr.en   = !done && last_step;
  assign wr.data = lcg_val;
  assign wr_addr = entry_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= GEN_SEED;
      step_r  <= '0;
      entry_r <= '0;
    end else begin
      value_r <= value_nxt;
      step_r  <= step_nxt;
      entry_r <= entry_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/nmwx_lane.sv */
// one lane: index reduction modulo the table size, private key table copy,
// lookup and xor of one metadata word; depends on nmwx_pkg
`timescale 1ns / 1ps
`default_nettype none

module nmwx_lane #(
  parameter int TABLE_ENTRIES = 256
) (
  input  wire logic                                  clk,
  input  wire nmwx_pkg::pipe_ctl_t                   ctl,
  input  wire logic [nmwx_pkg::WORD_W-1:0]           in_sum,
  input  wire logic [nmwx_pkg::WORD_W-1:0]           in_word,
  input  wire nmwx_pkg::tbl_wr_t                     wr,
  input  wire logic [$clog2(TABLE_ENTRIES)-1:0]      wr_addr,
  output logic [nmwx_pkg::WORD_W-1:0]                plain_word
);
  import nmwx_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  // floor(2^32 / N): quotient estimate is exact or one low
  localparam longint unsigned RECIP_L = (64'd1 << 32) / TABLE_ENTRIES;
  localparam logic [WORD_W-1:0] RECIP = RECIP_L[WORD_W-1:0];
  localparam logic [WORD_W-1:0] TE_W  = WORD_W'(TABLE_ENTRIES);
  localparam logic [IDX_W:0]    TE_R  = (IDX_W + 1)'(TABLE_ENTRIES);

  logic [WORD_W-1:0] key_mem [TABLE_ENTRIES];

  logic [WORD_W-1:0]   sum_s1_r, word_s1_r;
  logic [WORD_W-1:0]   quot_s2_r, sum_s2_r, word_s2_r;
  logic [IDX_W-1:0]    idx_s3_r;
  logic [WORD_W-1:0]   word_s3_r;
  logic [WORD_W-1:0]   key_s4_r, word_s4_r;

  logic [2*WORD_W-1:0] prod;
  logic [WORD_W-1:0]   diff;
  logic [IDX_W:0]      rem, rem_fix;

  assign prod    = {{WORD_W{1'b0}}, sum_s1_r} * {{WORD_W{1'b0}}, RECIP};
  assign diff    = sum_s2_r - quot_s2_r * TE_W;
  assign rem     = diff[IDX_W:0];
  assign rem_fix = (rem >= TE_R) ? (rem - TE_R) : rem;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      key_mem[wr_addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en1) begin
      sum_s1_r  <= in_sum;
      word_s1_r <= in_word;
    end
    if (ctl.en2) begin
      quot_s2_r <= prod[2*WORD_W-1:WORD_W];
      sum_s2_r  <= sum_s1_r;
      word_s2_r <= word_s1_r;
    end
    if (ctl.en3) begin
      idx_s3_r  <= rem_fix[IDX_W-1:0];
      word_s3_r <= word_s2_r;
    end
    if (ctl.en4) begin
      key_s4_r  <= key_mem[idx_s3_r];
      word_s4_r <= word_s3_r;
    end
  end

  assign plain_word = word_s4_r ^ key_s4_r;

endmodule

`default_nettype wire

/* tb/sv/meta_unwhiten_checker.sv */
// scoreboard for nand_meta_whitening_xor_top: predicts each unwhitened result
// depends on nothing but its ports; the key table is rebuilt here from the lcg
`timescale 1ns / 1ps

module meta_unwhiten_checker #(
  parameter int TABLE_ENTRIES   = 256,
  parameter int STEPS_PER_ENTRY = 763
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_page_address,
  input  logic [31:0] in_meta_word0,
  input  logic [31:0] in_meta_word1,
  input  logic [31:0] in_meta_word2,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_plain_word0,
  input  logic [31:0] out_plain_word1,
  input  logic [31:0] out_plain_word2,
  output int          errors,
  output int          pending,
  output int          results_checked
);

  localparam logic [31:0] LCG_SEED = 32'h50F4546A;
  localparam logic [31:0] LCG_MUL  = 32'h0019660D;
  localparam logic [31:0] LCG_INC  = 32'h3C6EF35F;

  typedef logic [2:0][31:0] plain_words_t;

  logic [31:0]  key_table [TABLE_ENTRIES];
  plain_words_t expected_plain [$];
  plain_words_t got_words;
  plain_words_t exp_words;

  // key table as it stands once the fill after reset is done
  initial begin
    logic [31:0] lcg;
    lcg = LCG_SEED;
    for (int e = 0; e < TABLE_ENTRIES; e++) begin
      for (int s = 0; s < STEPS_PER_ENTRY; s++) lcg = lcg * LCG_MUL + LCG_INC;
      key_table[e] = lcg;
    end
    errors          = 0;
    pending         = 0;
    results_checked = 0;
  end

  // word k uses entry (page + k) mod entries, sum wraps at 32 bits
  function automatic plain_words_t unwhiten(input logic [31:0] page,
                                            input plain_words_t meta);
    plain_words_t plain;
    logic [31:0]  sum;
    for (int k = 0; k < 3; k++) begin
      sum      = page + 32'(k);
      plain[k] = meta[k] ^ key_table[sum % TABLE_ENTRIES];
    end
    return plain;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got_words = {out_plain_word2, out_plain_word1, out_plain_word0};
        results_checked++;
        if (expected_plain.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, got %h %h %h", $time,
                   out_plain_word0, out_plain_word1, out_plain_word2);
        end else begin
          exp_words = expected_plain.pop_front();
          for (int k = 0; k < 3; k++) begin
            if (got_words[k] !== exp_words[k]) begin
              errors++;
              $display("%0t: plain_word%0d expected %h actual %h", $time, k,
                       exp_words[k], got_words[k]);
            end
          end
        end
      end
      if (in_valid && !in_stall)
        expected_plain.push_back(unwhiten(in_page_address,
          {in_meta_word2, in_meta_word1, in_meta_word0}));
    end
    pending = expected_plain.size();
  end

endmodule

/* tb/sv/tb_nand_meta_whitening_xor_top.sv */
// testbench top for nand_meta_whitening_xor_top: stimulus, stalls and verdict
// depends on the block under test and on meta_unwhiten_checker
`timescale 1ns / 1ps

module tb_nand_meta_whitening_xor_top;

  // nothing is accepted during the table fill after reset, so the idle
  // watchdog has to sit well above the length of that fill
  localparam int IDLE_LIMIT   = 600_000;
  localparam int DRAIN_LIMIT  = 20_000;
  localparam int HOLD_CYCLES  = 60;
  localparam int RANDOM_ITEMS = 530;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_page_address = '0;
  logic [31:0] in_meta_word0 = '0;
  logic [31:0] in_meta_word1 = '0;
  logic [31:0] in_meta_word2 = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_plain_word0;
  logic [31:0] out_plain_word1;
  logic [31:0] out_plain_word2;

  int errors;
  int pending;
  int results_checked;

  // pacing knobs, changed between phases by the stimulus
  int send_gap_max = 4;
  int rx_wait_max  = 4;
  logic hold_off = 1'b0;
  logic pressure_go = 1'b0;

  int items_sent = 0;
  int rx_wait = 0;
  int rx_draw;
  int idle_cycles = 0;
  int stall_run = 0;
  int longest_in_stall = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  nand_meta_whitening_xor_top uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_page_address (in_page_address),
    .in_meta_word0   (in_meta_word0),
    .in_meta_word1   (in_meta_word1),
    .in_meta_word2   (in_meta_word2),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_plain_word0 (out_plain_word0),
    .out_plain_word1 (out_plain_word1),
    .out_plain_word2 (out_plain_word2)
  );

  meta_unwhiten_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_page_address (in_page_address),
    .in_meta_word0   (in_meta_word0),
    .in_meta_word1   (in_meta_word1),
    .in_meta_word2   (in_meta_word2),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_plain_word0 (out_plain_word0),
    .out_plain_word1 (out_plain_word1),
    .out_plain_word2 (out_plain_word2),
    .errors          (errors),
    .pending         (pending),
    .results_checked (results_checked)
  );

  // result side: after each transfer wait a drawn number of cycles,
  // and hold off entirely while the pressure window is open
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait   <= 0;
    end else if (hold_off) begin
      out_stall <= 1'b1;
    end else if (rx_wait != 0) begin
      out_stall <= 1'b1;
      rx_wait   <= rx_wait - 1;
    end else if (out_valid && !out_stall) begin
      rx_draw = $urandom_range(0, rx_wait_max);
      out_stall <= (rx_draw != 0);
      rx_wait   <= (rx_draw == 0) ? 0 : rx_draw - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // long receiver hold-off, counted here, while the sender keeps offering
  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // watchdog on cycles with no transfer on either channel; also tracks how
  // long the input was held back once the table was ready
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (in_valid && in_stall && items_sent > 0) begin
      stall_run <= stall_run + 1;
      if (stall_run + 1 > longest_in_stall) longest_in_stall <= stall_run + 1;
    end else begin
      stall_run <= 0;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("nand_meta_whitening_xor_top: mismatch");
      $finish;
    end
  end

  // one input transfer; valid stays high straight into the next item when
  // the drawn gap is zero
  task automatic send_meta(input logic [31:0] page, input logic [31:0] w0,
                           input logic [31:0] w1, input logic [31:0] w2);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_page_address <= page;
    in_meta_word0   <= w0;
    in_meta_word1   <= w1;
    in_meta_word2   <= w2;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // mostly random words, now and then all zeros or all ones
  function automatic logic [31:0] meta_pattern();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random();
    logic [31:0] page;
    case ($urandom_range(0, 5))
      // pages whose index runs past the end of the table
      0: page = {24'($urandom), 8'($urandom_range(250, 255))};
      // pages at the very top, where page + k wraps the 32-bit sum
      1: page = 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
      default: page = $urandom;
    endcase
    send_meta(page, meta_pattern(), meta_pattern(), meta_pattern());
  endtask

  initial begin
    int drain;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: table ends, top-of-range wrap, all-zero and all-one words
    send_meta(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_meta(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_meta(32'h0000_0001, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_meta(32'h0000_00FD, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_meta(32'h0000_00FE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_meta(32'h0000_00FF, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    send_meta(32'h0000_0100, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_meta(32'hFFFF_FFFD, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_meta(32'hFFFF_FFFE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_meta(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_meta(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_meta(32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    send_meta(32'h8000_0000, 32'h8000_0001, 32'h0000_0001, 32'h8000_0000);
    send_meta(32'h1234_5678, 32'hDEAD_BEEF, 32'h0123_4567, 32'h89AB_CDEF);
    send_meta(32'hAAAA_AAAA, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    send_meta(32'h5555_5555, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);

    // random, switching between idling and back-to-back stretches on
    // either side; one stretch raises the long receiver hold-off
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) begin
        send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 4;
        rx_wait_max  = ($urandom_range(0, 2) == 0) ? 0 : 4;
      end
      if (i == 200) begin
        send_gap_max = 0;
        pressure_go  = 1'b1;
      end
      send_random();
    end
    in_valid <= 1'b0;

    // let everything drain, then a few cycles for anything stray
    drain = 0;
    while (pending != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);

    $display("sent %0d metadata items, checked %0d unwhitened results",
             items_sent, results_checked);
    $display("longest input backpressure after table fill: %0d cycles",
             longest_in_stall);
    if (errors == 0 && pending == 0) begin
      $display("nand_meta_whitening_xor_top: match");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, pending);
      $display("nand_meta_whitening_xor_top: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/nmwx_pkg.sv
hdl/nmwx_gen.sv
hdl/nmwx_lane.sv
hdl/nand_meta_whitening_xor_top.sv
tb/sv/meta_unwhiten_checker.sv
tb/sv/tb_nand_meta_whitening_xor_top.sv
